@@ rtl/zdci_pkg.sv @@
package zdci_pkg;

   localparam int NODE_COUNT = 21;
   localparam int SEG_W      = $clog2(NODE_COUNT);
   localparam int TIME_W     = 32;
   localparam int CNT_W      = 15;
   localparam int PROD_W     = TIME_W + CNT_W;
   localparam int MAG_W      = PROD_W + 1;
   localparam int DIV_W      = TIME_W + CNT_W - 1;
   localparam int STEP_W     = $clog2(CNT_W);
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MULT,
      ST_PREP,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;
      logic seg_step;
      logic mult;
      logic prep;
      logic div_step;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic clamp;
      logic seg_more;
      logic div_last;
      logic out_free;
   } status_type;

   function automatic logic [TIME_W-1:0] node_time(input logic [SEG_W-1:0] idx);
      logic [TIME_W-1:0] t;
      unique case (idx)
         5'd0:    t = 32'd0;
         5'd1:    t = 32'd1000;
         5'd2:    t = 32'd2000;
         5'd3:    t = 32'd3000;
         5'd4:    t = 32'd4000;
         5'd5:    t = 32'd5000;
         5'd6:    t = 32'd6000;
         5'd7:    t = 32'd8000;
         5'd8:    t = 32'd10000;
         5'd9:    t = 32'd15000;
         5'd10:   t = 32'd20000;
         5'd11:   t = 32'd30000;
         5'd12:   t = 32'd45000;
         5'd13:   t = 32'd60000;
         5'd14:   t = 32'd75000;
         5'd15:   t = 32'd90000;
         5'd16:   t = 32'd120000;
         5'd17:   t = 32'd150000;
         5'd18:   t = 32'd180000;
         5'd19:   t = 32'd220000;
         5'd20:   t = 32'd300000;
         default: t = 32'd300000;
      endcase
      return t;
   endfunction

   function automatic logic [CNT_W-1:0] node_counts(input logic [SEG_W-1:0] idx);
      logic [CNT_W-1:0] c;
      unique case (idx)
         5'd0:    c = 15'd16223;
         5'd1:    c = 15'd15286;
         5'd2:    c = 15'd15200;
         5'd3:    c = 15'd15155;
         5'd4:    c = 15'd15099;
         5'd5:    c = 15'd15053;
         5'd6:    c = 15'd15048;
         5'd7:    c = 15'd14953;
         5'd8:    c = 15'd14966;
         5'd9:    c = 15'd15296;
         5'd10:   c = 15'd15424;
         5'd11:   c = 15'd15614;
         5'd12:   c = 15'd16016;
         5'd13:   c = 15'd16319;
         5'd14:   c = 15'd16606;
         5'd15:   c = 15'd16800;
         5'd16:   c = 15'd17670;
         5'd17:   c = 15'd18540;
         5'd18:   c = 15'd19410;
         5'd19:   c = 15'd20570;
         5'd20:   c = 15'd22890;
         default: c = 15'd22890;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/zdci_ctrl.sv @@
module zdci_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  zdci_pkg::status_type  status,
   output zdci_pkg::cmd_type     cmd
);

   zdci_pkg::state_type state_ff;
   zdci_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zdci_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         zdci_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = zdci_pkg::ST_SEARCH;
            end
         end
         zdci_pkg::ST_SEARCH: begin
            priority if (status.clamp) begin
               state_in = zdci_pkg::ST_WRITE;
            end else if (!status.seg_more) begin
               state_in = zdci_pkg::ST_MULT;
            end
         end
         zdci_pkg::ST_MULT:   state_in = zdci_pkg::ST_PREP;
         zdci_pkg::ST_PREP:   state_in = zdci_pkg::ST_DIVIDE;
         zdci_pkg::ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = zdci_pkg::ST_WRITE;
            end
         end
         zdci_pkg::ST_WRITE: begin
            if (status.out_free) begin
               state_in = zdci_pkg::ST_IDLE;
            end
         end
         default: state_in = zdci_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         zdci_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         zdci_pkg::ST_SEARCH: cmd.seg_step = !status.clamp && status.seg_more;
         zdci_pkg::ST_MULT:   cmd.mult     = 1'b1;
         zdci_pkg::ST_PREP:   cmd.prep     = 1'b1;
         zdci_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         zdci_pkg::ST_WRITE:  cmd.write    = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

@@ rtl/zdci_datapath.sv @@
module zdci_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [zdci_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [zdci_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  zdci_pkg::cmd_type                 cmd,
   output zdci_pkg::status_type              status
);

   logic [zdci_pkg::TIME_W-1:0] t_ff;
   logic                        lo_ff;
   logic                        hi_ff;
   logic [zdci_pkg::SEG_W-1:0]  seg_ff;
   logic [zdci_pkg::SEG_W-1:0]  seg_in;
   logic [zdci_pkg::SEG_W-1:0]  seg_next;
   logic [zdci_pkg::PROD_W-1:0] prod_ff;
   logic [zdci_pkg::TIME_W-1:0] span_ff;
   logic [zdci_pkg::CNT_W-1:0]  base_ff;
   logic                        neg_ff;
   logic [zdci_pkg::MAG_W-1:0]  mag_ff;
   logic [zdci_pkg::MAG_W-1:0]  mag_in;
   logic [zdci_pkg::DIV_W-1:0]  div_ff;
   logic [zdci_pkg::CNT_W-1:0]  q_ff;
   logic [zdci_pkg::STEP_W-1:0] step_ff;
   logic [zdci_pkg::STEP_W-1:0] step_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [zdci_pkg::CNT_W-1:0]  rsp_data_ff;
   logic [zdci_pkg::CNT_W-1:0]  rsp_data_in;

   logic [zdci_pkg::TIME_W-1:0] t_lo;
   logic [zdci_pkg::CNT_W-1:0]  c_lo;
   logic [zdci_pkg::CNT_W-1:0]  c_hi;
   logic                        neg;
   logic [zdci_pkg::CNT_W-1:0]  dmag;
   logic [zdci_pkg::TIME_W-1:0] offs;
   logic                        ge;

   assign seg_next = seg_ff + 1'b1;
   assign t_lo     = zdci_pkg::node_time(seg_ff);
   assign c_lo     = zdci_pkg::node_counts(seg_ff);
   assign c_hi     = zdci_pkg::node_counts(seg_next);
   assign neg      = c_hi < c_lo;
   assign dmag     = neg ? (c_lo - c_hi) : (c_hi - c_lo);
   assign offs     = t_ff - t_lo;
   assign ge       = mag_ff >= zdci_pkg::MAG_W'(div_ff);

   always_comb begin
      seg_in = seg_ff;
      if (cmd.load) begin
         seg_in = '0;
      end else if (cmd.seg_step) begin
         seg_in = seg_next;
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      step_in = step_ff;
      if (cmd.prep) begin
         mag_in  = {1'b0, prod_ff} + zdci_pkg::MAG_W'(span_ff >> 1);
         step_in = zdci_pkg::STEP_W'(zdci_pkg::CNT_W - 1);
      end else if (cmd.div_step) begin
         if (ge) begin
            mag_in = mag_ff - zdci_pkg::MAG_W'(div_ff);
         end
         if (step_ff != '0) begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_comb begin
      priority if (lo_ff) begin
         rsp_data_in = zdci_pkg::node_counts('0);
      end else if (hi_ff) begin
         rsp_data_in = zdci_pkg::node_counts(zdci_pkg::SEG_W'(zdci_pkg::NODE_COUNT - 1));
      end else if (neg_ff) begin
         rsp_data_in = base_ff - q_ff;
      end else begin
         rsp_data_in = base_ff + q_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      if (cmd.load) begin
         t_ff  <= req_tdata[zdci_pkg::TIME_W-1:0];
         lo_ff <= req_tdata[zdci_pkg::TIME_W-1:0] <= zdci_pkg::node_time('0);
         hi_ff <= req_tdata[zdci_pkg::TIME_W-1:0]
                  >= zdci_pkg::node_time(zdci_pkg::SEG_W'(zdci_pkg::NODE_COUNT - 1));
      end
      if (cmd.mult) begin
         prod_ff <= {{zdci_pkg::TIME_W{1'b0}}, dmag} * {{zdci_pkg::CNT_W{1'b0}}, offs};
         span_ff <= zdci_pkg::node_time(seg_next) - t_lo;
         base_ff <= c_lo;
         neg_ff  <= neg;
      end
      if (cmd.prep) begin
         div_ff <= {span_ff, {(zdci_pkg::CNT_W - 1){1'b0}}};
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         div_ff <= div_ff >> 1;
         q_ff   <= {q_ff[zdci_pkg::CNT_W-2:0], ge};
      end
      if (cmd.write) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.clamp    = lo_ff | hi_ff;
   assign status.seg_more = (seg_ff < zdci_pkg::SEG_W'(zdci_pkg::NODE_COUNT - 2))
                            && (t_ff > zdci_pkg::node_time(seg_next));
   assign status.div_last = step_ff == '0;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = zdci_pkg::RSP_DATA_W'(rsp_data_ff);

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      seg_ff <= zdci_pkg::SEG_W'(zdci_pkg::NODE_COUNT - 2))
      else $error("segment index beyond last segment");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= zdci_pkg::STEP_W'(zdci_pkg::CNT_W - 1))
      else $error("division step count out of range");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (mag_ff < {1'b0, div_ff, 1'b0}))
      else $error("partial remainder escaped divisor bound");

   a_write_clears_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> rsp_tvalid)
      else $error("result register not loaded");

endmodule

@@ rtl/zero_drift_curve_interpolator_unit.sv @@
// Inputs at or beyond the curve ends go from the search state straight to the write.
// Otherwise, with k the segment index (0..19), the unit runs k + 1 search compares,
// a multiply, a setup step, a 15-step shift-subtract divider and a write.
// No request is taken until the result is written; a waiting result stalls the write.
// Reset: synchronous, active high; clears the controller and the result valid.
module zero_drift_curve_interpolator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [zdci_pkg::REQ_DATA_W-1:0] req_tdata,   // [31:0] uptime_ms
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [zdci_pkg::RSP_DATA_W-1:0] rsp_tdata    // [14:0] zero_counts, [15] zero
);

   zdci_pkg::cmd_type    cmd;
   zdci_pkg::status_type status;

   zdci_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   zdci_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

@@ sim/zero_drift_curve_interpolator_unit_tb.sv @@
`timescale 1ns / 100ps

module zero_drift_curve_interpolator_unit_tb;

   import zdci_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 60;
   localparam int GAP_MAX      = 6;

   typedef struct packed {
      logic [TIME_W-1:0] uptime_ms;
      logic [CNT_W-1:0]  zero_counts;
   } zero_beat_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int unsigned curve_ms [NODE_COUNT] = '{
      0, 1000, 2000, 3000, 4000, 5000, 6000, 8000, 10000, 15000, 20000,
      30000, 45000, 60000, 75000, 90000, 120000, 150000, 180000, 220000, 300000
   };
   int curve_counts [NODE_COUNT] = '{
      16223, 15286, 15200, 15155, 15099, 15053, 15048, 14953, 14966, 15296,
      15424, 15614, 16016, 16319, 16606, 16800, 17670, 18540, 19410, 20570, 22890
   };

   zero_beat_type expected_zero_q [$];
   int            mismatch_count = 0;
   int            cycle_count    = 0;
   int            send_calm      = 0;
   int            take_calm      = 0;

   zero_drift_curve_interpolator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [CNT_W-1:0] zero_offset_at(input logic [TIME_W-1:0] t);
      int          seg;
      int unsigned span;
      int unsigned offs;
      int          base;
      int          delta;
      logic [63:0] mag;
      logic [63:0] quot;
      int          zero;
      if (t <= curve_ms[0])
         return CNT_W'(curve_counts[0]);
      if (t >= curve_ms[NODE_COUNT-1])
         return CNT_W'(curve_counts[NODE_COUNT-1]);
      seg = 0;
      while (seg < NODE_COUNT - 2 && t > curve_ms[seg+1])
         seg++;
      base = curve_counts[seg];
      span = curve_ms[seg+1] - curve_ms[seg];
      if (span == 0)
         return CNT_W'(base);
      offs  = t - curve_ms[seg];
      delta = curve_counts[seg+1] - base;
      if (delta >= 0) begin
         mag  = 64'(delta) * 64'(offs) + 64'(span / 2);
         quot = mag / 64'(span);
         zero = base + int'(quot);
      end else begin
         mag  = 64'(-delta) * 64'(offs) + 64'(span / 2);
         quot = mag / 64'(span);
         zero = base - int'(quot);
      end
      return CNT_W'(zero);
   endfunction

   // hold for a run of items now and then so that some stretches have no gaps
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   task automatic report_mismatch(input string what, input logic [TIME_W-1:0] elapsed,
                                  input int got, input int want);
      $display("mismatch %s: uptime_ms %0d got %0d expected %0d",
               what, elapsed, got, want);
      mismatch_count++;
   endtask

   task automatic send_elapsed(input logic [TIME_W-1:0] t);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      do @(posedge clock); while (!req_tready);
      expected_zero_q.push_back('{uptime_ms: t, zero_counts: zero_offset_at(t)});
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_zero_q.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin
      zero_beat_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_zero_q.size() == 0) begin
            report_mismatch("unexpected beat", '0, int'(rsp_tdata), 0);
         end else begin
            head = expected_zero_q.pop_front();
            if (rsp_tdata[CNT_W-1:0] !== head.zero_counts)
               report_mismatch("zero_counts", head.uptime_ms,
                               int'(rsp_tdata[CNT_W-1:0]), int'(head.zero_counts));
            if (rsp_tdata[RSP_DATA_W-1:CNT_W] !== '0)
               report_mismatch("padding", head.uptime_ms,
                               int'(rsp_tdata[RSP_DATA_W-1:CNT_W]), 0);
         end
      end
   end

   initial begin
      int gap;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = draw_gap(take_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic test_curve_edges();
      send_elapsed(32'd0);
      send_elapsed(32'd1);
      send_elapsed(32'd500);
      send_elapsed(32'd999);
      send_elapsed(32'd1000);
      send_elapsed(32'd1001);
      send_elapsed(32'd7000);
      send_elapsed(32'd8000);
      send_elapsed(32'd12500);
      send_elapsed(32'd15001);
      send_elapsed(32'd52500);
      send_elapsed(32'd90000);
      send_elapsed(32'd219999);
      send_elapsed(32'd220000);
      send_elapsed(32'd260000);
      send_elapsed(32'd299999);
      send_elapsed(32'd300000);
      send_elapsed(32'd300001);
      send_elapsed(32'h8000_0000);
      send_elapsed(32'hFFFF_FFFF);
      send_elapsed(32'h5555_5555);
      send_elapsed(32'hAAAA_AAAA);
   endtask

   task automatic test_node_hits();
      for (int n = 0; n < NODE_COUNT; n++)
         send_elapsed(curve_ms[n]);
   endtask

   // drain the pipe between short bursts
   task automatic test_drain_pause();
      for (int burst = 0; burst < 3; burst++) begin
         repeat ($urandom_range(3, 8))
            send_elapsed($urandom_range(1, 299999));
         wait_for_drain();
      end
   endtask

   task automatic test_random_times(input int count);
      logic [TIME_W-1:0] t;
      int                n;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            7: t = $urandom();
            8: t = $urandom_range(0, 12000);
            9: t = $urandom_range(300000, 32'hFFFF_FFFF);
            6: begin
               n = $urandom_range(0, NODE_COUNT - 1);
               t = curve_ms[n] + $urandom_range(0, 6) - 3;
            end
            default: t = $urandom_range(1, 299999);
         endcase
         send_elapsed(t);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_curve_edges();
      test_node_hits();
      test_drain_pause();
      test_random_times(990);

      wait_for_drain();
      repeat (SETTLE_TICKS) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
